// ===== design/lzw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared types and constants of the sliding-window encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

	localparam int unsigned WINDOW_DEF    = 2048;
	localparam int unsigned MAX_MATCH_DEF = 18;
	localparam int unsigned OFF_W         = 12;
	localparam int unsigned LEN_W         = 5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} lzw_in_t;

	typedef struct packed {
		logic [OFF_W-1:0] match_offset;
		logic [LEN_W-1:0] match_length;
		logic [7:0]       next_byte;
		logic             last_token;
	} lzw_out_t;

	typedef struct packed {
		logic shift;
		logic capture;
	} lzw_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/lzw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== design/lzw_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_cell
// One compare cell: holds a byte of the candidate string, passes it to its
// lower neighbor on each shift and registers its match against the lookahead.
// ----------------------------------------------------------------------------
module lzw_cell import lzw_pkg::*; (
	input  wire logic           clk,
	input  wire lzw_cell_ctrl_t ctrl,
	input  wire logic           entry,
	input  wire logic [7:0]     feed_byte,
	input  wire logic [7:0]     nb_byte,
	input  wire logic [7:0]     la_byte,
	output logic      [7:0]     held_byte,
	output logic                match_hit
);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			held_byte <= entry ? feed_byte : nb_byte;
		end
		if (ctrl.capture) begin
			match_hit <= (held_byte == la_byte);
		end
	end

endmodule

`default_nettype wire

// ===== design/lz77_window_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz77_window_encoder
// Greedy LZ77 encoder: history RAM, lookahead register file and a row of
// compare cells through which the history streams once per token.
// ----------------------------------------------------------------------------
//  channel   payload     handshake
//  byte      lzw_in_t    byte_valid / byte_ready
//  token     lzw_out_t   token_valid / token_ready
//
// A byte that decides no token passes through the decide state back to idle.
// A token's search streams the history RAM one byte a cycle through the cell
// row; then the consumed bytes (length + 1) move into the history, the last
// one once the output register is free. Reset clears counts only; no
// clearing pass. A stalled token stays in its output register; the next byte
// is taken meanwhile, and the following token waits for the register to free.
module lz77_window_encoder import lzw_pkg::*; #(
	parameter int unsigned WINDOW    = WINDOW_DEF,
	parameter int unsigned MAX_MATCH = MAX_MATCH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_ready,
	input  wire lzw_in_t  byte_item,
	output logic          token_valid,
	input  wire logic     token_ready,
	output lzw_out_t      token_item
);

	localparam int unsigned HW  = $clog2(WINDOW);
	localparam int unsigned FW  = $clog2(WINDOW + 1);
	localparam int unsigned LC  = MAX_MATCH + 1;
	localparam int unsigned LAW = $clog2(LC);
	localparam int unsigned LW  = $clog2(LC + 1);
	localparam int unsigned CW  = $clog2(MAX_MATCH + 1);
	localparam int unsigned NW  = $clog2(WINDOW + MAX_MATCH + 1);
	localparam int unsigned AW2 = $clog2(2 * WINDOW);

	typedef enum logic [1:0] {ST_IDLE, ST_DECIDE, ST_SEARCH, ST_CONSUME} state_t;

	state_t         state_q;
	logic [FW-1:0]  hf_q;
	logic [HW-1:0]  head_q;
	logic [HW-1:0]  ra_q;
	logic [LW-1:0]  lf_q;
	logic           drain_q;
	logic [CW-1:0]  cap_q;
	logic [NW-1:0]  n_q;
	logic [NW-1:0]  ic_q;
	logic [NW-1:0]  sc_q;
	logic [LAW-1:0] li_q;
	logic [FW-1:0]  oc_q;
	logic [CW-1:0]  best_len_q;
	logic [FW-1:0]  best_off_q;
	logic [CW-1:0]  u_q;

	logic           v_s1;
	logic           src_la_s1;
	logic [7:0]     la_s1;
	logic           cv_s2;
	logic           cv_s3;
	logic [FW-1:0]  off_s3;

	logic [7:0]     la_q [LC];
	logic [7:0]     ram_rdata;
	logic [7:0]     feed_byte;
	logic           push_en;
	logic           append_en;
	logic           issue;
	logic           src_la;
	logic [CW-1:0]  cand_len;
	logic [CW-1:0]  cap_new;
	logic [AW2-1:0] ra_sum;
	logic [HW-1:0]  ra_start;
	logic [HW-1:0]  head_next;
	logic [HW-1:0]  ra_next;
	logic [LW-1:0]  lf_dec;

	logic [7:0]      held [MAX_MATCH];
	logic [MAX_MATCH-1:0] hit;
	lzw_cell_ctrl_t  cell_ctrl;

	assign byte_ready = (state_q == ST_IDLE);
	assign append_en  = byte_valid && byte_ready;
	assign issue      = (state_q == ST_SEARCH) && (ic_q < n_q);
	assign src_la     = (ic_q >= NW'(hf_q));
	assign push_en    = (state_q == ST_CONSUME) && ((u_q != best_len_q) || !token_valid);
	assign feed_byte  = src_la_s1 ? la_s1 : ram_rdata;
	assign cap_new    = CW'(lf_q - 1'b1);
	assign lf_dec     = lf_q - 1'b1;
	assign head_next  = (head_q == HW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
	assign ra_next    = (ra_q == HW'(WINDOW - 1)) ? '0 : ra_q + 1'b1;

	// Oldest history byte sits hfill places behind the write head.
	assign ra_sum   = AW2'(head_q) + AW2'(WINDOW) - AW2'(hf_q);
	assign ra_start = (ra_sum >= AW2'(WINDOW)) ? HW'(ra_sum - AW2'(WINDOW)) : HW'(ra_sum);

	assign cell_ctrl.shift   = v_s1;
	assign cell_ctrl.capture = cv_s2;

	lzw_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (push_en),
		.waddr (head_q),
		.wdata (la_q[0]),
		.raddr (ra_q),
		.rdata (ram_rdata)
	);

	for (genvar k = 0; k < MAX_MATCH; k++) begin : g_cell
		lzw_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.entry     (cap_q == CW'(k + 1)),
			.feed_byte (feed_byte),
			.nb_byte   ((k == MAX_MATCH - 1) ? feed_byte : held[(k + 1) % MAX_MATCH]),
			.la_byte   (la_q[k]),
			.held_byte (held[k]),
			.match_hit (hit[k])
		);
	end

	// Run of matching cells from the start of the candidate, cut at cap.
	always_comb begin
		logic run;
		run      = 1'b1;
		cand_len = '0;
		for (int k = 0; k < MAX_MATCH; k++) begin
			if (run && hit[k] && (CW'(k) < cap_q)) begin
				cand_len = CW'(k + 1);
			end else begin
				run = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (append_en) begin
			la_q[lf_q[LAW-1:0]] <= byte_item.data_byte;
		end else if (push_en) begin
			for (int k = 0; k < LC - 1; k++) begin
				la_q[k] <= la_q[k + 1];
			end
		end
		la_s1     <= la_q[li_q];
		src_la_s1 <= src_la;
		off_s3    <= oc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hf_q        <= '0;
			head_q      <= '0;
			ra_q        <= '0;
			lf_q        <= '0;
			drain_q     <= 1'b0;
			cap_q       <= '0;
			n_q         <= '0;
			ic_q        <= '0;
			sc_q        <= '0;
			li_q        <= '0;
			oc_q        <= '0;
			best_len_q  <= '0;
			best_off_q  <= '0;
			u_q         <= '0;
			v_s1        <= 1'b0;
			cv_s2       <= 1'b0;
			cv_s3       <= 1'b0;
			token_valid <= 1'b0;
			token_item  <= '0;
		end else begin
			if (token_valid && token_ready) begin
				token_valid <= 1'b0;
			end
			v_s1  <= issue;
			cv_s2 <= v_s1 && ((sc_q + 1'b1) >= NW'(cap_q));
			cv_s3 <= cv_s2;
			if (v_s1) begin
				sc_q <= sc_q + 1'b1;
			end
			if (cv_s2) begin
				oc_q <= oc_q - 1'b1;
			end
			// Offsets fall over the sweep, so an equal length takes the smaller one.
			if (cv_s3 && (cand_len != '0) && (cand_len >= best_len_q)) begin
				best_len_q <= cand_len;
				best_off_q <= off_s3;
			end
			if (issue) begin
				ic_q <= ic_q + 1'b1;
				if (src_la) begin
					li_q <= li_q + 1'b1;
				end else begin
					ra_q <= ra_next;
				end
			end
			if (push_en) begin
				head_q <= head_next;
				if (hf_q < FW'(WINDOW)) begin
					hf_q <= hf_q + 1'b1;
				end
				lf_q <= lf_dec;
			end
			case (state_q)
				ST_IDLE: begin
					if (append_en) begin
						lf_q    <= lf_q + 1'b1;
						drain_q <= byte_item.stream_end;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					best_len_q <= '0;
					best_off_q <= '0;
					u_q        <= '0;
					if (drain_q || (lf_q == LW'(LC))) begin
						cap_q <= cap_new;
						n_q   <= NW'(hf_q) + NW'(cap_new) - 1'b1;
						ic_q  <= '0;
						sc_q  <= '0;
						li_q  <= '0;
						oc_q  <= hf_q;
						ra_q  <= ra_start;
						if ((cap_new == '0) || (hf_q == '0)) begin
							state_q <= ST_CONSUME;
						end else begin
							state_q <= ST_SEARCH;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					if (!issue && !v_s1 && !cv_s2 && !cv_s3) begin
						state_q <= ST_CONSUME;
					end
				end
				ST_CONSUME: begin
					if (u_q != best_len_q) begin
						u_q <= u_q + 1'b1;
					end else if (!token_valid) begin
						token_valid             <= 1'b1;
						token_item.match_offset <= OFF_W'(best_off_q);
						token_item.match_length <= LEN_W'(best_len_q);
						token_item.next_byte    <= la_q[0];
						token_item.last_token   <= !drain_q || (lf_dec == '0);
						if (!drain_q) begin
							state_q <= ST_IDLE;
						end else if (lf_dec == '0) begin
							hf_q    <= '0;
							head_q  <= '0;
							drain_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DECIDE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_la_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lf_q <= LW'(LC))
		else $error("lookahead count above capacity");

	a_hist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hf_q <= FW'(WINDOW))
		else $error("history count above window");

	a_match_off: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(token_valid) && (token_item.match_length != '0) |->
		(token_item.match_offset != '0) || (WINDOW > 4095))
		else $error("match without offset");

	a_ready_gap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_ready |=> !byte_ready)
		else $error("byte taken twice in a row");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte streams into the LZ77 window encoder under random idling on both
// channels, predicts the greedy (offset, length, next byte) tokens in the
// testbench and compares every token beat against the predicted sequence.
// ----------------------------------------------------------------------------
module tb_top;
	import lzw_pkg::*;

	localparam int WIN  = WINDOW_DEF;
	localparam int MAXM = MAX_MATCH_DEF;
	localparam int LCAP = MAXM + 1;

	logic     clk;
	logic     arst_n;
	logic     byte_valid;
	logic     byte_ready;
	lzw_in_t  byte_item;
	logic     token_valid;
	logic     token_ready;
	lzw_out_t token_item;

	lz77_window_encoder dut (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(byte_valid), .byte_ready(byte_ready), .byte_item(byte_item),
		.token_valid(token_valid), .token_ready(token_ready), .token_item(token_item)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Encoder state as the testbench tracks it.
	logic [7:0] hist_mem [WIN];
	int         hist_cnt;
	int         hist_wr;
	logic [7:0] look_mem [LCAP];
	int         look_cnt;

	lzw_in_t  byte_queue [$];
	lzw_out_t token_queue [$];
	int       errors;
	bit       stim_done;
	bit       hold_off;

	function automatic logic [7:0] hist_byte(int d);
		return hist_mem[(hist_wr + WIN - d) % WIN];
	endfunction

	task automatic decide_token(output lzw_out_t tok);
		int cap, best_len, best_off, k, used;
		logic [7:0] src;
		cap = look_cnt - 1;
		if (cap > MAXM)
			cap = MAXM;
		best_len = 0;
		best_off = 0;
		for (int i = 1; i <= hist_cnt; i++) begin
			k = 0;
			while (k < cap) begin
				src = (k < i) ? hist_byte(i - k) : look_mem[k - i];
				if (src != look_mem[k])
					break;
				k++;
			end
			if (k > best_len) begin
				best_len = k;
				best_off = i;
			end
		end
		tok.match_offset = best_off[OFF_W-1:0];
		tok.match_length = best_len[LEN_W-1:0];
		tok.next_byte    = look_mem[best_len];
		tok.last_token   = 1'b0;
		used = best_len + 1;
		for (int j = 0; j < used; j++) begin
			hist_mem[hist_wr] = look_mem[j];
			hist_wr = (hist_wr + 1) % WIN;
			if (hist_cnt < WIN)
				hist_cnt++;
		end
		for (int j = 0; j + used < look_cnt; j++)
			look_mem[j] = look_mem[j + used];
		look_cnt -= used;
	endtask

	task automatic predict_tokens(input lzw_in_t b);
		lzw_out_t toks [$];
		lzw_out_t t;
		if (look_cnt < LCAP) begin
			look_mem[look_cnt] = b.data_byte;
			look_cnt++;
		end
		if (!b.stream_end) begin
			if (look_cnt >= LCAP) begin
				decide_token(t);
				toks = {toks, t};
			end
		end else begin
			while (look_cnt > 0) begin
				decide_token(t);
				toks = {toks, t};
			end
			hist_cnt = 0;
			hist_wr  = 0;
		end
		if (toks.size() > 0)
			toks[toks.size() - 1].last_token = 1'b1;
		foreach (toks[i])
			token_queue = {token_queue, toks[i]};
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Byte driver.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_item  <= '0;
			send_gap   <= 0;
		end else begin
			if (byte_valid && byte_ready) begin
				predict_tokens(byte_item);
			end
			if (!byte_valid || byte_ready) begin
				if (send_gap > 0) begin
					byte_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (byte_queue.size() > 0) begin
					byte_valid <= 1'b1;
					byte_item  <= byte_queue.pop_front();
					send_gap   <= pick_gap();
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Token monitor and ready generator.
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ready <= 1'b0;
			recv_gap    <= 0;
		end else begin
			if (token_valid && token_ready) begin
				if (token_queue.size() == 0) begin
					$display("%0t: unexpected token off=%0d len=%0d nb=%0h last=%0b", $time,
						token_item.match_offset, token_item.match_length,
						token_item.next_byte, token_item.last_token);
					errors++;
				end else begin
					lzw_out_t e;
					e = token_queue.pop_front();
					if (e.match_offset !== token_item.match_offset) begin
						$display("%0t: match_offset expected %0d actual %0d", $time,
							e.match_offset, token_item.match_offset);
						errors++;
					end
					if (e.match_length !== token_item.match_length) begin
						$display("%0t: match_length expected %0d actual %0d", $time,
							e.match_length, token_item.match_length);
						errors++;
					end
					if (e.next_byte !== token_item.next_byte) begin
						$display("%0t: next_byte expected %0h actual %0h", $time,
							e.next_byte, token_item.next_byte);
						errors++;
					end
					if (e.last_token !== token_item.last_token) begin
						$display("%0t: last_token expected %0b actual %0b", $time,
							e.last_token, token_item.last_token);
						errors++;
					end
				end
			end
			if (hold_off) begin
				token_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				token_ready <= 1'b0;
				recv_gap    <= recv_gap - 1;
			end else begin
				token_ready <= 1'b1;
				recv_gap    <= pick_gap();
			end
		end
	end

	task automatic add_byte(input logic [7:0] d, input bit last);
		lzw_in_t b;
		b.data_byte  = d;
		b.stream_end = last;
		byte_queue = {byte_queue, b};
	endtask

	// A stream drawn mostly from a set of four random bytes so that long matches show up.
	task automatic add_stream(input int len);
		logic [7:0] phrase [4];
		foreach (phrase[i])
			phrase[i] = 8'($urandom);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 3))
				0: add_byte(8'($urandom), i == len - 1);
				default: add_byte(phrase[$urandom_range(0, 3)] ^
					(($urandom_range(0, 9) == 0) ? 8'h01 : 8'h00), i == len - 1);
			endcase
		end
	endtask

	initial begin
		int total;
		errors    = 0;
		stim_done = 1'b0;
		hold_off  = 1'b0;
		hist_cnt  = 0;
		hist_wr   = 0;
		look_cnt  = 0;
		arst_n    = 1'b0;

		// Directed: a lone last byte (only literals), extremes, a long run that
		// overlaps into the lookahead and caps at the drain, a maximum match.
		add_byte(8'h00, 1'b1);
		add_byte(8'hff, 1'b0);
		add_byte(8'h00, 1'b1);
		for (int i = 0; i < 22; i++)
			add_byte(8'haa, i == 21);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Long receiver hold-off while bytes keep coming: the block must stall.
		hold_off = 1'b1;
		fork
			begin
				int cnt;
				cnt = 0;
				while (cnt < 400) begin
					@(posedge clk);
					cnt++;
				end
				hold_off = 1'b0;
			end
		join_none

		// Random streams, most short, with a few long ones; a filler stream
		// first so the hold-off has tokens to back up.
		add_stream(60);
		total = 85;
		while (total < 220) begin
			int len;
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 25);
			if (len > 220 - total)
				len = 220 - total;
			add_stream(len);
			total += len;
		end
		stim_done = 1'b1;
	end

	initial begin
		int idle;
		wait (stim_done);
		@(posedge clk);
		while (byte_queue.size() > 0 || byte_valid || token_queue.size() > 0)
			@(posedge clk);
		idle = 0;
		while (idle < 200) begin
			@(posedge clk);
			idle++;
		end
		if (errors == 0 && token_queue.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb_top: errors");
		$finish;
	end

endmodule
